// ----- hdl/cht_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cht_pkg: shared constants and types of the chained hash table
// Widths, operation and status codes used by the core.
// ----------------------------------------------------------------------------
package cht_pkg;
  localparam int BUCKET_COUNT = 64;
  localparam int POOL_DEPTH   = 256;
  localparam int BW = $clog2(BUCKET_COUNT);
  localparam int NW = $clog2(POOL_DEPTH);
  localparam int LW = NW + 1;             // link width, POOL_DEPTH means empty
  localparam logic [LW-1:0] NIL = LW'(POOL_DEPTH);

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_SEARCH = 2'd1,
    OP_DELETE = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_RSVD      = 2'd3
  } status_t;
endpackage

// ----- hdl/cht_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cht_req_if / cht_rsp_if: request and response channels
// Valid/ready handshake; a word moves when both are high at a clock edge.
// ----------------------------------------------------------------------------
interface cht_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [23:0] key_high;
  logic [19:0] key_low;
  logic [31:0] record;
  modport source (output valid, op, key_high, key_low, record, input ready);
  modport sink   (input valid, op, key_high, key_low, record, output ready);
endinterface

interface cht_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] record_out;
  modport source (output valid, status, record_out, input ready);
  modport sink   (input valid, status, record_out, output ready);
endinterface

// ----- hdl/chained_hash_table_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chained_hash_table_unit: hash table with separate chaining
// Usage:
//   req (sink) takes one word per operation: op, key_high, key_low, record.
//   rsp (source) returns exactly one word per request: status, record_out.
//   Insert pushes a node at the head of its bucket chain (no duplicate
//   check); search returns the first match; delete unlinks it and frees
//   the node. The bucket is key_high modulo 64, i.e. its low six bits.
// Sequence and throughput:
//   Insert passes through S_START, S_FREE and S_RESP; no-op, pool-full
//   insert and a search or delete on an empty bucket go from S_START to S_RESP.
//   Otherwise search and delete spend S_READ (registered node read) and S_CMP
//   (compare) on each chain node visited, plus S_LINK to relink on a delete hit.
//   One request is in flight at a time; req.ready is low while working.
// Reset:
//   Synchronous, active high. A valid bit per bucket head clears, so every
//   chain reads empty; the free list empties and the never-used count
//   returns to zero. Node and head memories are not cleared.
// Stall:
//   The response is held in its output register until rsp.ready; the next
//   request is taken from the cycle after the response leaves.
// ----------------------------------------------------------------------------
module chained_hash_table_unit (
  input  logic clk,
  input  logic rst,
  cht_req_if.sink   req,
  cht_rsp_if.source rsp
);
  import cht_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_START = 7'b0000010,  // look up the bucket head / pick a free node
    S_FREE  = 7'b0000100,  // wait for the free node's next link
    S_READ  = 7'b0001000,  // issue read of the current node
    S_CMP   = 7'b0010000,  // compare registered node data
    S_LINK  = 7'b0100000,  // patch predecessor link on delete
    S_RESP  = 7'b1000000
  } state_t;

  state_t state;

  // node memory, one word per node, single read port with registered data
  typedef struct packed {
    logic [23:0]   kh;
    logic [19:0]   kl;
    logic [31:0]   rec;
    logic [LW-1:0] nxt;
  } node_t;

  node_t node_mem [POOL_DEPTH];
  node_t rd_data;
  logic [NW-1:0] rd_addr;
  logic          wr_en;
  logic [NW-1:0] wr_addr;
  node_t         wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      node_mem[wr_addr] <= wr_data;
    end
    rd_data <= node_mem[rd_addr];
  end

  // bucket head memory with registered read; a head reads as empty until
  // its valid bit is set by the first write after reset
  logic [LW-1:0]           bucket_head [BUCKET_COUNT];
  logic [BUCKET_COUNT-1:0] head_valid;
  logic [LW-1:0]           head_rd;
  logic [LW-1:0] free_head;
  logic [LW-1:0] unused_count;

  // latched request
  op_t           op;
  logic [23:0]   kh;
  logic [19:0]   kl;
  logic [31:0]   rec;
  logic [BW-1:0] bkt;

  logic [LW-1:0] cur;
  logic [LW-1:0] prev;
  logic [LW-1:0] steps;   // bounded walk, never exceeds the pool
  status_t       status;
  logic [31:0]   rout;
  logic          rsp_valid;

  logic          patch_head;  // delete: unlink at bucket head, not predecessor

  assign req.ready      = (state == S_IDLE) && !rsp_valid;
  assign rsp.valid      = rsp_valid;
  assign rsp.status     = status;
  assign rsp.record_out = rout;

  logic hit;
  assign hit = (rd_data.kh == kh) && (rd_data.kl == kl);

  logic [BW-1:0] head_addr;
  logic          head_we;
  logic [LW-1:0] head_wdata;
  logic [LW-1:0] head_cur;

  // read the head of the incoming word's bucket at the accepting edge
  assign head_addr  = (state == S_IDLE) ? req.key_high[BW-1:0] : bkt;
  assign head_cur   = head_valid[bkt] ? head_rd : NIL;
  assign head_we    = !rst && ((state == S_FREE) ||
                      (state == S_CMP && hit && op == OP_DELETE && prev == NIL));
  assign head_wdata = (state == S_FREE) ? cur : rd_data.nxt;

  always_ff @(posedge clk) begin
    if (head_we) begin
      bucket_head[bkt] <= head_wdata;
    end
    head_rd <= bucket_head[head_addr];
  end

  // memory port control
  always_comb begin
    rd_addr = cur[NW-1:0];
    wr_en   = 1'b0;
    wr_addr = cur[NW-1:0];
    wr_data = rd_data;
    unique case (state)
      S_START: begin
        rd_addr = free_head[NW-1:0];
      end
      S_FREE: begin
        // write the new node into the picked slot
        wr_en   = 1'b1;
        wr_data = '{kh: kh, kl: kl, rec: rec, nxt: head_cur};
      end
      S_CMP: begin
        if (hit && op == OP_DELETE) begin
          // freed node points at the old free list head
          wr_en       = 1'b1;
          wr_data     = rd_data;
          wr_data.nxt = free_head;
          rd_addr     = prev[NW-1:0];
        end
      end
      S_LINK: begin
        // rewrite predecessor with the unlinked node's successor
        wr_en       = !patch_head;
        wr_addr     = prev[NW-1:0];
        wr_data     = rd_data;
        wr_data.nxt = steps;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      rsp_valid    <= 1'b0;
      free_head    <= NIL;
      unused_count <= '0;
      head_valid   <= '0;
    end else begin
      if (rsp_valid && rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid && req.ready) begin
            op    <= op_t'(req.op);
            kh    <= req.key_high;
            kl    <= req.key_low;
            rec   <= req.record;
            bkt   <= req.key_high[BW-1:0];
            state <= S_START;
          end
        end
        S_START: begin
          status <= ST_DONE;
          rout   <= '0;
          prev   <= NIL;
          steps  <= '0;
          unique case (op)
            OP_INSERT: begin
              if (free_head != NIL) begin
                cur   <= free_head;
                state <= S_FREE;   // next link arrives from memory
              end else if (unused_count != NIL) begin
                cur          <= unused_count;
                unused_count <= unused_count + 1'b1;
                free_head    <= NIL;
                state        <= S_FREE;
              end else begin
                status <= ST_FULL;
                state  <= S_RESP;
              end
            end
            OP_SEARCH, OP_DELETE: begin
              status <= ST_NOT_FOUND;
              cur    <= head_cur;
              state  <= (head_cur == NIL) ? S_RESP : S_READ;
            end
            default: state <= S_RESP;
          endcase
        end
        S_FREE: begin
          // pop the free list when the node came from it
          if (cur == free_head) begin
            free_head <= rd_data.nxt;
          end
          head_valid[bkt] <= 1'b1;
          state           <= S_RESP;
        end
        S_READ: begin
          state <= S_CMP;
        end
        S_CMP: begin
          if (hit) begin
            status <= ST_DONE;
            rout   <= rd_data.rec;
            if (op == OP_DELETE) begin
              free_head  <= cur;
              steps      <= rd_data.nxt;   // reuse as successor hold
              patch_head <= (prev == NIL);
              state      <= S_LINK;
            end else begin
              state <= S_RESP;
            end
          end else begin
            prev  <= cur;
            cur   <= rd_data.nxt;
            steps <= steps + 1'b1;
            state <= (rd_data.nxt == NIL || steps == NIL - 1'b1) ? S_RESP : S_READ;
          end
        end
        S_LINK: begin
          state <= S_RESP;
        end
        S_RESP: begin
          rsp_valid <= 1'b1;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // one response per request: no new request while a response is waiting
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !req.ready) else $error("request taken while response pending");
  a_resp_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == S_RESP)) else $error("response out of sequence");
  a_held: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.ready |=> rsp_valid && $stable(rout) && $stable(status))
    else $error("response dropped under stall");
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status != ST_DONE |-> rout == '0) else $error("record on miss");
endmodule
